// ----- hw/rtl/byte_count_to_readable_text_macros.svh -----
// ----------------------------------------------------------------------------
// Byte count to readable text: assertion macros
// Shared concurrent assertion forms, sampled on i_clk with i_rst_n as the
// synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_COUNT_TO_READABLE_TEXT_MACROS_SVH
`define BYTE_COUNT_TO_READABLE_TEXT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in byte count formatter");

// The consequent must hold in the cycle after the antecedent.
`define BCRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in byte count formatter");

`endif

// ----- hw/rtl/bcrt_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte count formatter package
// Shared widths, ASCII codes, the unit letter table and the stage load struct.
// ----------------------------------------------------------------------------
package bcrt_pkg;

    localparam int COUNT_W   = 63;
    localparam int STEP_BITS = 10;
    localparam int VAL_W     = 10;
    localparam int STEPS_W   = 3;
    localparam int MAX_STEPS = 6;
    localparam int CHAR_W    = 6;
    localparam int SUFFIX_W  = 7;
    localparam int LIMIT_VAL = 999;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_DOT  = 6'd46;

    // One load enable per pipeline stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_ld;

    // Unit letter for a number of divisions by 1024.
    function automatic logic [SUFFIX_W-1:0] unit_letter(input logic [STEPS_W-1:0] steps);
        logic [SUFFIX_W-1:0] letter;
        case (steps)
            3'd0:    letter = 7'd66;  // B
            3'd1:    letter = 7'd75;  // K
            3'd2:    letter = 7'd77;  // M
            3'd3:    letter = 7'd71;  // G
            3'd4:    letter = 7'd84;  // T
            3'd5:    letter = 7'd80;  // P
            3'd6:    letter = 7'd69;  // E
            default: letter = 7'd90;  // Z, cannot occur for a 63-bit count
        endcase
        return letter;
    endfunction

endpackage

// ----- hw/rtl/byte_count_to_readable_text.sv -----
// ----------------------------------------------------------------------------
// Byte count to readable text
// Formats a byte count as four ASCII characters in binary units.
// ----------------------------------------------------------------------------
// The block takes one 63-bit byte count per beat and returns four characters:
// either three decimal digits and a unit letter (for example "512K"), or a
// digit, a dot, a tenths digit and a unit letter (for example "1.5M"). The
// unit letter steps through B, K, M, G, T, P and E with each division by 1024.
// It is a four-stage pipeline: one beat may enter in every cycle while the
// output is not stalled. The four register stages are division count, value
// select, reciprocal multiplies, and character assembly. Each stage holds
// its beat while the stage after it is full and stalled, so a stall on the
// output backs up through the pipeline without loss or repeat.
// ----------------------------------------------------------------------------
`include "byte_count_to_readable_text_macros.svh"

module byte_count_to_readable_text (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bcrt_pkg::COUNT_W-1:0]      i_byte_count,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bcrt_pkg::CHAR_W-1:0]       o_first_char,
    output logic [bcrt_pkg::CHAR_W-1:0]       o_second_char,
    output logic [bcrt_pkg::CHAR_W-1:0]       o_third_char,
    output logic [bcrt_pkg::SUFFIX_W-1:0]     o_suffix_char
);

    // Valid bits for the four stages; they move with the data registers.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    // A stage can take a new beat when it is empty or its beat moves on.
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;

    bcrt_pkg::t_stage_ld            w_ld;
    logic [bcrt_pkg::VAL_W-1:0]     w_val;
    logic [bcrt_pkg::STEP_BITS-1:0] w_rem;
    logic [bcrt_pkg::STEPS_W-1:0]   w_steps;

    // The outer characters of a result are always decimal digits.
    logic                           w_digits_ok;

    assign w_rdy4 = !r_v4 || !i_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_ld.s1 = w_rdy1;
    assign w_ld.s2 = w_rdy2;
    assign w_ld.s3 = w_rdy3;
    assign w_ld.s4 = w_rdy4;

    assign o_stall = !w_rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stages one and two: division count and scaled value with remainder.
    bcrt_scale u_scale (
        .i_clk        (i_clk),
        .i_ld         (w_ld),
        .i_byte_count (i_byte_count),
        .o_val        (w_val),
        .o_rem        (w_rem),
        .o_steps      (w_steps)
    );

    // Stages three and four: decimal digits and the output characters.
    bcrt_digits u_digits (
        .i_clk         (i_clk),
        .i_ld          (w_ld),
        .i_val         (w_val),
        .i_rem         (w_rem),
        .i_steps       (w_steps),
        .o_first_char  (o_first_char),
        .o_second_char (o_second_char),
        .o_third_char  (o_third_char),
        .o_suffix_char (o_suffix_char)
    );

    assign w_digits_ok = (o_first_char >= bcrt_pkg::ASCII_ZERO) &&
                         (o_first_char <= bcrt_pkg::ASCII_ZERO + 6'd9) &&
                         (o_third_char >= bcrt_pkg::ASCII_ZERO) &&
                         (o_third_char <= bcrt_pkg::ASCII_ZERO + 6'd9);

    // An accepted beat always lands in the first stage.
    `BCRT_ASSERT_NEXT(a_accept_loads, i_valid && !o_stall, r_v1)

    // A beat in stage three is kept while stage four is full and stalled.
    `BCRT_ASSERT_NEXT(a_s3_holds, r_v3 && !w_rdy4, r_v3)

    // The reciprocal digit split must give decimal digits in the outer places.
    `BCRT_ASSERT_SAME(a_digits_ok, o_valid, w_digits_ok)

endmodule

// ----- hw/rtl/bcrt_scale.sv -----
// ----------------------------------------------------------------------------
// Byte count formatter: scaling stages
// Stage 1 finds how many divisions by 1024 bring the count to 999 or less.
// Stage 2 selects the scaled value and the remainder of the last division.
// ----------------------------------------------------------------------------
module bcrt_scale (
    input  logic                              i_clk,
    input  bcrt_pkg::t_stage_ld               i_ld,
    input  logic [bcrt_pkg::COUNT_W-1:0]      i_byte_count,
    output logic [bcrt_pkg::VAL_W-1:0]        o_val,
    output logic [bcrt_pkg::STEP_BITS-1:0]    o_rem,
    output logic [bcrt_pkg::STEPS_W-1:0]      o_steps
);

    logic [bcrt_pkg::COUNT_W-1:0]   r_cnt;
    logic [bcrt_pkg::STEPS_W-1:0]   r_steps1;
    logic [bcrt_pkg::STEPS_W-1:0]   n_steps1;
    logic [bcrt_pkg::VAL_W-1:0]     r_val;
    logic [bcrt_pkg::VAL_W-1:0]     n_val;
    logic [bcrt_pkg::STEP_BITS-1:0] r_rem;
    logic [bcrt_pkg::STEP_BITS-1:0] n_rem;
    logic [bcrt_pkg::STEPS_W-1:0]   r_steps2;

    // The shifted copies fall monotonically, so the last one above the limit
    // decides the division count. The compares are independent.
    always_comb begin
        n_steps1 = '0;
        for (int j = 0; j < bcrt_pkg::MAX_STEPS; j++) begin
            if ((i_byte_count >> (bcrt_pkg::STEP_BITS * j)) >
                bcrt_pkg::COUNT_W'(bcrt_pkg::LIMIT_VAL)) begin
                n_steps1 = bcrt_pkg::STEPS_W'(j + 1);
            end
        end
    end

    always_comb begin
        case (r_steps1)
            3'd0: begin
                n_val = r_cnt[9:0];
                n_rem = '0;
            end
            3'd1: begin
                n_val = r_cnt[19:10];
                n_rem = r_cnt[9:0];
            end
            3'd2: begin
                n_val = r_cnt[29:20];
                n_rem = r_cnt[19:10];
            end
            3'd3: begin
                n_val = r_cnt[39:30];
                n_rem = r_cnt[29:20];
            end
            3'd4: begin
                n_val = r_cnt[49:40];
                n_rem = r_cnt[39:30];
            end
            3'd5: begin
                n_val = r_cnt[59:50];
                n_rem = r_cnt[49:40];
            end
            3'd6: begin
                n_val = {7'd0, r_cnt[62:60]};
                n_rem = r_cnt[59:50];
            end
            default: begin
                n_val = '0;
                n_rem = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_cnt    <= i_byte_count;
            r_steps1 <= n_steps1;
        end
        if (i_ld.s2) begin
            r_val    <= n_val;
            r_rem    <= n_rem;
            r_steps2 <= r_steps1;
        end
    end

    assign o_val   = r_val;
    assign o_rem   = r_rem;
    assign o_steps = r_steps2;

endmodule

// ----- hw/rtl/bcrt_digits.sv -----
// ----------------------------------------------------------------------------
// Byte count formatter: decimal stages
// Stage 3 forms quotients by reciprocal multiplication and the tenths digit.
// Stage 4 forms the remaining digits and the four output characters.
// ----------------------------------------------------------------------------
module bcrt_digits (
    input  logic                              i_clk,
    input  bcrt_pkg::t_stage_ld               i_ld,
    input  logic [bcrt_pkg::VAL_W-1:0]        i_val,
    input  logic [bcrt_pkg::STEP_BITS-1:0]    i_rem,
    input  logic [bcrt_pkg::STEPS_W-1:0]      i_steps,
    output logic [bcrt_pkg::CHAR_W-1:0]       o_first_char,
    output logic [bcrt_pkg::CHAR_W-1:0]       o_second_char,
    output logic [bcrt_pkg::CHAR_W-1:0]       o_third_char,
    output logic [bcrt_pkg::SUFFIX_W-1:0]     o_suffix_char
);

    logic [17:0]                    w_prod10;
    logic [15:0]                    w_prod100;
    logic [13:0]                    w_prod_tenth;
    logic [bcrt_pkg::VAL_W-1:0]     r_val;
    logic [6:0]                     r_q10;
    logic [3:0]                     r_hund;
    logic [3:0]                     r_tenth;
    logic [bcrt_pkg::STEPS_W-1:0]   r_steps;
    logic [3:0]                     w_tens;
    logic [3:0]                     w_units;
    logic [bcrt_pkg::CHAR_W-1:0]    n_first;
    logic [bcrt_pkg::CHAR_W-1:0]    n_second;
    logic [bcrt_pkg::CHAR_W-1:0]    n_third;
    logic [bcrt_pkg::CHAR_W-1:0]    r_first;
    logic [bcrt_pkg::CHAR_W-1:0]    r_second;
    logic [bcrt_pkg::CHAR_W-1:0]    r_third;
    logic [bcrt_pkg::SUFFIX_W-1:0]  r_suffix;

    // For values below 1000, v*205>>11 equals v/10 and v*41>>12 equals v/100.
    assign w_prod10     = 18'(i_val) * 18'd205;
    assign w_prod100    = 16'(i_val) * 16'd41;
    assign w_prod_tenth = 14'(i_rem) * 14'd10;

    assign w_tens  = 4'(r_q10 - 7'(r_hund) * 7'd10);
    assign w_units = 4'(r_val - 10'(r_q10) * 10'd10);

    always_comb begin
        if (r_val <= 10'd9) begin
            n_first  = bcrt_pkg::ASCII_ZERO + 6'(r_val[3:0]);
            n_second = bcrt_pkg::ASCII_DOT;
            n_third  = bcrt_pkg::ASCII_ZERO + 6'(r_tenth);
        end else begin
            n_first  = bcrt_pkg::ASCII_ZERO + 6'(r_hund);
            n_second = bcrt_pkg::ASCII_ZERO + 6'(w_tens);
            n_third  = bcrt_pkg::ASCII_ZERO + 6'(w_units);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r_val   <= i_val;
            r_q10   <= w_prod10[17:11];
            r_hund  <= w_prod100[15:12];
            r_tenth <= w_prod_tenth[13:10];
            r_steps <= i_steps;
        end
        if (i_ld.s4) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
            r_suffix <= bcrt_pkg::unit_letter(r_steps);
        end
    end

    assign o_first_char  = r_first;
    assign o_second_char = r_second;
    assign o_third_char  = r_third;
    assign o_suffix_char = r_suffix;

endmodule

// ----- verif/readable_text_check.sv -----
// ----------------------------------------------------------------------------
// Readable text check
// Watches both channels of the byte count formatter. It predicts the four
// characters of every accepted count, holds them in order and compares each
// result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module readable_text_check
    import bcrt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [COUNT_W-1:0]  i_byte_count,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [CHAR_W-1:0]   i_first_char,
    input  logic [CHAR_W-1:0]   i_second_char,
    input  logic [CHAR_W-1:0]   i_third_char,
    input  logic [SUFFIX_W-1:0] i_suffix_char,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int unsigned SCALE         = 1024;
    localparam int unsigned DECIMAL       = 10;
    localparam int unsigned MAX_DIVISIONS = 9;
    localparam int unsigned LAST_LETTER   = 8;
    localparam int unsigned SHORT_LIMIT   = 9;
    localparam logic [7:0]  ASCII_DOT_8   = 8'd46;
    // Unit letters, leftmost first, one byte each.
    localparam logic [8*9-1:0] UNIT_TEXT  = "BKMGTPEZY";

    typedef struct packed {
        logic [CHAR_W-1:0]   first_char;
        logic [CHAR_W-1:0]   second_char;
        logic [CHAR_W-1:0]   third_char;
        logic [SUFFIX_W-1:0] suffix_char;
    } t_readable_text;

    t_readable_text expected_text_q [$];
    int             mismatch_count = 0;

    // Scale the count down by 1024 until it fits in three digits, then build
    // either the three-digit form or the digit, dot, tenths form.
    function automatic t_readable_text format_byte_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] scaled;
        int unsigned        remainder;
        int unsigned        divisions;
        int unsigned        digits;
        int unsigned        letter_idx;
        t_readable_text     text;
        scaled    = count;
        remainder = 0;
        divisions = 0;
        while (scaled > LIMIT_VAL && divisions < MAX_DIVISIONS) begin
            remainder = scaled % SCALE;
            scaled    = scaled / SCALE;
            divisions++;
        end
        if (scaled > SHORT_LIMIT) begin
            digits = (scaled > LIMIT_VAL) ? LIMIT_VAL : scaled;
            text.third_char  = ASCII_ZERO + digits % DECIMAL;
            digits = digits / DECIMAL;
            text.second_char = ASCII_ZERO + digits % DECIMAL;
            digits = digits / DECIMAL;
            text.first_char  = ASCII_ZERO + digits % DECIMAL;
        end else begin
            text.first_char  = ASCII_ZERO + scaled;
            text.second_char = ASCII_DOT_8;
            text.third_char  = ASCII_ZERO + ((remainder * DECIMAL / SCALE) % DECIMAL);
        end
        letter_idx = (divisions > LAST_LETTER) ? LAST_LETTER : divisions;
        text.suffix_char = UNIT_TEXT[8*(LAST_LETTER-letter_idx) +: 8];
        return text;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_readable_text want;
        if (i_rst_n) begin
            // Results are matched before new counts are queued, so a result
            // can never pair with a count accepted on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_text_q.size() == 0) begin
                    $error("result beat with no count waiting: %0d %0d %0d %0d",
                           i_first_char, i_second_char, i_third_char, i_suffix_char);
                    mismatch_count++;
                end else begin
                    want = expected_text_q.pop_front();
                    compare_field("first_char", want.first_char, i_first_char);
                    compare_field("second_char", want.second_char, i_second_char);
                    compare_field("third_char", want.third_char, i_third_char);
                    compare_field("suffix_char", want.suffix_char, i_suffix_char);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_text_q.push_back(format_byte_count(i_byte_count));
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_text_q.size();
    end

endmodule

// ----- verif/byte_count_to_readable_text_tb.sv -----
// ----------------------------------------------------------------------------
// Byte count to readable text testbench
// Drives byte counts into the formatter, applies random backpressure and
// lets the readable text check compare every result with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_count_to_readable_text_tb;
    import bcrt_pkg::*;

    // Run shape. The directed counts come first, the rest are random.
    localparam int NUM_DIRECTED = 24;
    localparam int ITEM_TOTAL   = 1850;
    // The last beats run with no idling on either side.
    localparam int QUIET_TAIL   = 200;
    // After this many beats the receiver holds off long enough that the
    // pipeline fills and the block stalls its input.
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 64;
    localparam int RESET_CYCLES = 6;
    // Four register stages; a few extra cycles catch any stray result.
    localparam int DRAIN_CYCLES = 12;
    // The limit allows for the worst case per beat (sender gap, receiver stall,
    // latency) several times over the whole run.
    localparam int LIMIT_CYCLES = 250000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [COUNT_W-1:0]  i_byte_count;
    logic                o_valid;
    logic                i_stall;
    logic [CHAR_W-1:0]   o_first_char;
    logic [CHAR_W-1:0]   o_second_char;
    logic [CHAR_W-1:0]   o_third_char;
    logic [SUFFIX_W-1:0] o_suffix_char;

    int fail_count;
    int text_pending;

    // Shared between the sender and the receiver processes.
    int   sent_count  = 0;
    logic quiet_tail  = 1'b0;
    logic hold_active = 1'b0;

    byte_count_to_readable_text uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_byte_count  (i_byte_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_first_char  (o_first_char),
        .o_second_char (o_second_char),
        .o_third_char  (o_third_char),
        .o_suffix_char (o_suffix_char)
    );

    readable_text_check u_text_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_byte_count  (i_byte_count),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_first_char  (o_first_char),
        .i_second_char (o_second_char),
        .i_third_char  (o_third_char),
        .i_suffix_char (o_suffix_char),
        .o_fail_count  (fail_count),
        .o_pending     (text_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that outlives the cycle limit is a failure.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver. Stall comes in bursts, with the burst rate redrawn as the run
    // goes on so that some stretches see no stall at all.
    // Once, the receiver holds off for a long stretch while the sender keeps
    // offering beats. In the quiet tail the output is never stalled.
    initial begin : receiver
        int stall_pct;
        int cycle_idx;
        logic hold_done;
        i_stall <= 1'b0;
        stall_pct = 0;
        cycle_idx = 0;
        hold_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cycle_idx++;
            if (cycle_idx % 200 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_active = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_active = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Sender and verdict. A beat is offered with a nonblocking update at the
    // clock edge and held unchanged until an edge sees valid high and stall
    // low. Between beats the sender may idle.
    initial begin : sender
        logic [COUNT_W-1:0] count;
        logic [63:0]        wide;
        int unsigned        gap_pct;
        int unsigned        k;
        int                 idx;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_byte_count <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct = 0;
        for (idx = 0; idx < ITEM_TOTAL; idx++) begin
            if (idx % 128 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 50;
                endcase
            end
            if (idx >= ITEM_TOTAL - QUIET_TAIL) begin
                quiet_tail = 1'b1;
            end
            if (idx < NUM_DIRECTED) begin
                // Directed counts: single digits with no division, the edges
                // of the three-digit form, values that divide down to zero
                // with a remainder, each unit letter and the largest count.
                case (idx)
                    0:       count = 63'd0;
                    1:       count = 63'd5;
                    2:       count = 63'd9;
                    3:       count = 63'd10;
                    4:       count = 63'd99;
                    5:       count = 63'd100;
                    6:       count = 63'd999;
                    7:       count = 63'd1000;
                    8:       count = 63'd1023;
                    9:       count = 63'd1024;
                    10:      count = 63'd1535;
                    11:      count = 63'd10239;
                    12:      count = 63'd10240;
                    13:      count = 63'd1023999;
                    14:      count = 63'd1024000;
                    15:      count = 63'd1048575;
                    16:      count = 63'd1 << 30;
                    17:      count = 63'd3 << 40;
                    18:      count = 63'd1 << 50;
                    19:      count = 63'd1 << 60;
                    20:      count = 63'd1 << 62;
                    21:      count = {COUNT_W{1'b1}};
                    22:      count = 63'h2AAA_AAAA_AAAA_AAAA;
                    default: count = ~63'h2AAA_AAAA_AAAA_AAAA;
                endcase
            end else begin
                // Random counts: full width, random magnitude, values near
                // the points where the scaling or the format changes, and
                // plain small counts.
                wide = {$urandom, $urandom};
                case ($urandom_range(0, 3))
                    0: count = wide[COUNT_W-1:0];
                    1: count = wide[COUNT_W-1:0] >> $urandom_range(0, COUNT_W - 1);
                    2: begin
                        k = $urandom_range(0, 5);
                        case ($urandom_range(0, 2))
                            0:       count = 63'd10;
                            1:       count = 63'd1000;
                            default: count = 63'd1024;
                        endcase
                        count = count << (10 * k);
                        count = count + $urandom_range(0, 16) - 8;
                    end
                    default: count = $urandom_range(0, 20000);
                endcase
            end
            // No idling while the receiver holds off, so the block fills up.
            if (!quiet_tail && !hold_active && $urandom_range(0, 99) < gap_pct) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_valid      <= 1'b1;
            i_byte_count <= count;
            do @(posedge i_clk); while (o_stall);
            sent_count++;
        end
        i_valid <= 1'b0;
        // One edge so that the last accepted beat shows in the pending count.
        @(posedge i_clk);
        while (text_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
